// ===== src/mse_pkg.sv =====
package mse_pkg;

    localparam int DATA_W        = 32;
    localparam int DEPTH_DEFAULT = 64;

    // status from the sort sequencer to the top level
    typedef struct packed {
        logic done;      // one-cycle pulse at the end of the last pass
        logic src_bank;  // bank that holds the current (and finally sorted) data
    } sort_stat_t;

endpackage

// ===== src/mse_ram.sv =====
module mse_ram #(
    parameter int WIDTH = mse_pkg::DATA_W,
    parameter int DEPTH = mse_pkg::DEPTH_DEFAULT,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr_a,
    input  logic [AW-1:0]    raddr_b,
    output logic [WIDTH-1:0] rdata_a,
    output logic [WIDTH-1:0] rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

// ===== src/mse_sorter.sv =====
module mse_sorter #(
    parameter int DEPTH  = mse_pkg::DEPTH_DEFAULT,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CNT_W = $clog2(DEPTH + 1),
    localparam int CW    = $clog2(DEPTH) + 2
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      start,
    input  logic [CNT_W-1:0]          n,
    output logic [AW-1:0]             rd_addr_a,
    output logic [AW-1:0]             rd_addr_b,
    input  logic [mse_pkg::DATA_W-1:0] rd_data_a,
    input  logic [mse_pkg::DATA_W-1:0] rd_data_b,
    output logic                      wr_en,
    output logic [AW-1:0]             wr_addr,
    output logic [mse_pkg::DATA_W-1:0] wr_data,
    output mse_pkg::sort_stat_t       stat
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_SETUP = 3'd1;
    localparam logic [2:0] ST_READ  = 3'd2;
    localparam logic [2:0] ST_CMP   = 3'd3;
    localparam logic [2:0] ST_DONE  = 3'd4;

    logic [2:0]    state_reg, state_next;
    logic [CW-1:0] n_reg, n_next;
    logic [CW-1:0] width_reg, width_next;
    logic [CW-1:0] lo_reg, lo_next;
    logic [CW-1:0] mid_reg, mid_next;
    logic [CW-1:0] hi_reg, hi_next;
    logic [CW-1:0] i_reg, i_next;
    logic [CW-1:0] j_reg, j_next;
    logic [CW-1:0] k_reg, k_next;
    logic          src_reg, src_next;

    logic [CW-1:0] sum_mid;
    logic [CW-1:0] sum_hi;
    logic [CW-1:0] width_dbl;
    logic          take_left;

    assign width_dbl = width_reg << 1;
    assign sum_mid   = lo_reg + width_reg;
    assign sum_hi    = lo_reg + width_dbl;

    // the shared comparator: left wins when the right run is exhausted or left is strictly smaller
    assign take_left = (i_reg < mid_reg) &&
                       ((j_reg >= hi_reg) || ($signed(rd_data_a) < $signed(rd_data_b)));

    assign rd_addr_a = i_reg[AW-1:0];
    assign rd_addr_b = j_reg[AW-1:0];
    assign wr_en     = (state_reg == ST_CMP);
    assign wr_addr   = k_reg[AW-1:0];
    assign wr_data   = take_left ? rd_data_a : rd_data_b;

    assign stat.done     = (state_reg == ST_DONE);
    assign stat.src_bank = src_reg;

    always_comb begin
        state_next = state_reg;
        n_next     = n_reg;
        width_next = width_reg;
        lo_next    = lo_reg;
        mid_next   = mid_reg;
        hi_next    = hi_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        k_next     = k_reg;
        src_next   = src_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (start) begin
                    n_next     = CW'(n);
                    width_next = CW'(1);
                    lo_next    = '0;
                    src_next   = 1'b0;
                    state_next = ST_SETUP;
                end
            end
            ST_SETUP: begin
                if (lo_reg >= n_reg) begin
                    // pass finished, the destination bank becomes the source
                    width_next = width_dbl;
                    src_next   = ~src_reg;
                    lo_next    = '0;
                    state_next = (width_dbl >= n_reg) ? ST_DONE : ST_SETUP;
                end else begin
                    mid_next   = (sum_mid > n_reg) ? n_reg : sum_mid;
                    hi_next    = (sum_hi > n_reg) ? n_reg : sum_hi;
                    i_next     = lo_reg;
                    j_next     = (sum_mid > n_reg) ? n_reg : sum_mid;
                    k_next     = lo_reg;
                    state_next = ST_READ;
                end
            end
            ST_READ: begin
                if (k_reg == hi_reg) begin
                    lo_next    = hi_reg;
                    state_next = ST_SETUP;
                end else begin
                    state_next = ST_CMP;
                end
            end
            ST_CMP: begin
                k_next = k_reg + CW'(1);
                if (take_left) begin
                    i_next = i_reg + CW'(1);
                end else begin
                    j_next = j_reg + CW'(1);
                end
                state_next = ST_READ;
            end
            ST_DONE: begin
                state_next = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            src_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            src_reg   <= src_next;
        end
        n_reg     <= n_next;
        width_reg <= width_next;
        lo_reg    <= lo_next;
        mid_reg   <= mid_next;
        hi_reg    <= hi_next;
        i_reg     <= i_next;
        j_reg     <= j_next;
        k_reg     <= k_next;
    end

    // a write always lands inside the run being merged
    a_write_in_run: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CMP) |-> (k_reg < hi_reg))
        else $error("merge write beyond end of run");

    // some element is left to take whenever a write happens
    a_source_left: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CMP) |-> ((i_reg < mid_reg) || (j_reg < hi_reg)))
        else $error("merge step with both runs exhausted");

    // output count matches consumed inputs within a run
    a_count_track: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_READ) |->
            (k_reg - lo_reg == (i_reg - lo_reg) + (j_reg - mid_reg)))
        else $error("merge indexes out of step");

    // start is only given to an idle sequencer
    a_start_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        start |-> (state_reg == ST_IDLE))
        else $error("sort started while busy");

endmodule

// ===== src/merge_sort_engine.sv =====
// merge_sort_engine: collects signed 32-bit values and returns them in ascending order
//
// input stream (s_): one value per request in s_tdata, s_tlast on the final value of
// an array. values are taken one per cycle while loading; up to DEPTH are kept and
// any beyond that are discarded (the array still ends on s_tlast).
// after s_tlast the block sorts bottom-up with two ping-pong banks and a single
// comparator, then streams the result on m_: m_tdata is the value, m_tlast marks the
// final one, m_tuser is set on every result if values were discarded.
// for n stored values, sorting takes max(1, ceil(log2 n)) passes; every merge step
// is a registered bank read followed by a compare and write. each result is
// emitted by a bank read, a load of the output register and a wait for m_tready.
// s_tready is low from s_tlast until the last result has been taken.
// a low m_tready holds the current result in the output register and stalls the
// block; nothing is lost.
// aresetn (synchronous, active low) returns the block to loading with an empty
// array and no pending results; bank contents are not cleared.
module merge_sort_engine #(
    parameter int DEPTH  = mse_pkg::DEPTH_DEFAULT,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CNT_W = $clog2(DEPTH + 1)
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [mse_pkg::DATA_W-1:0] s_tdata,   // [31:0] value
    input  logic                       s_tlast,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [mse_pkg::DATA_W-1:0] m_tdata,   // [31:0] sorted_value
    output logic                       m_tlast,
    output logic                       m_tuser    // [0] dropped
);

    localparam logic [2:0] ST_LOAD      = 3'd0;
    localparam logic [2:0] ST_START     = 3'd1;
    localparam logic [2:0] ST_SORT      = 3'd2;
    localparam logic [2:0] ST_EMIT_RD   = 3'd3;
    localparam logic [2:0] ST_EMIT_LD   = 3'd4;
    localparam logic [2:0] ST_EMIT_WAIT = 3'd5;

    logic [2:0]                 state_reg, state_next;
    logic [CNT_W-1:0]           count_reg, count_next;
    logic                       ovf_reg, ovf_next;
    logic [CNT_W-1:0]           idx_reg, idx_next;
    logic                       out_valid_reg, out_valid_next;
    logic                       out_last_reg, out_last_next;
    logic [mse_pkg::DATA_W-1:0] out_data_reg, out_data_next;

    logic                       s_accept;
    logic                       load_we;
    logic                       sort_start;
    mse_pkg::sort_stat_t        sort_stat;

    logic [AW-1:0]              seq_ra, seq_rb, seq_wa;
    logic                       seq_we;
    logic [mse_pkg::DATA_W-1:0] seq_wd;

    logic [AW-1:0]              rd_addr_a;
    logic                       bank0_we, bank1_we;
    logic [AW-1:0]              bank0_wa;
    logic [mse_pkg::DATA_W-1:0] bank0_wd;
    logic [mse_pkg::DATA_W-1:0] bank0_rd_a, bank0_rd_b, bank1_rd_a, bank1_rd_b;
    logic [mse_pkg::DATA_W-1:0] rd_a, rd_b;

    assign s_tready   = (state_reg == ST_LOAD);
    assign s_accept   = s_tvalid && s_tready;
    assign load_we    = s_accept && (count_reg < CNT_W'(DEPTH));
    assign sort_start = (state_reg == ST_START);

    // the merge writes the bank opposite to the one it reads
    assign bank0_we = load_we || (seq_we && sort_stat.src_bank);
    assign bank1_we = seq_we && !sort_stat.src_bank;
    assign bank0_wa = load_we ? count_reg[AW-1:0] : seq_wa;
    assign bank0_wd = load_we ? s_tdata : seq_wd;

    assign rd_addr_a = (state_reg == ST_SORT) ? seq_ra : idx_reg[AW-1:0];
    assign rd_a      = sort_stat.src_bank ? bank1_rd_a : bank0_rd_a;
    assign rd_b      = sort_stat.src_bank ? bank1_rd_b : bank0_rd_b;

    mse_ram #(
        .WIDTH (mse_pkg::DATA_W),
        .DEPTH (DEPTH)
    ) u_bank0 (
        .aclk    (aclk),
        .we      (bank0_we),
        .waddr   (bank0_wa),
        .wdata   (bank0_wd),
        .raddr_a (rd_addr_a),
        .raddr_b (seq_rb),
        .rdata_a (bank0_rd_a),
        .rdata_b (bank0_rd_b)
    );

    mse_ram #(
        .WIDTH (mse_pkg::DATA_W),
        .DEPTH (DEPTH)
    ) u_bank1 (
        .aclk    (aclk),
        .we      (bank1_we),
        .waddr   (seq_wa),
        .wdata   (seq_wd),
        .raddr_a (rd_addr_a),
        .raddr_b (seq_rb),
        .rdata_a (bank1_rd_a),
        .rdata_b (bank1_rd_b)
    );

    mse_sorter #(
        .DEPTH (DEPTH)
    ) u_sorter (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (sort_start),
        .n         (count_reg),
        .rd_addr_a (seq_ra),
        .rd_addr_b (seq_rb),
        .rd_data_a (rd_a),
        .rd_data_b (rd_b),
        .wr_en     (seq_we),
        .wr_addr   (seq_wa),
        .wr_data   (seq_wd),
        .stat      (sort_stat)
    );

    always_comb begin
        state_next     = state_reg;
        count_next     = count_reg;
        ovf_next       = ovf_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        out_last_next  = out_last_reg;
        out_data_next  = out_data_reg;
        unique case (state_reg)
            ST_LOAD: begin
                if (s_accept) begin
                    if (load_we) begin
                        count_next = count_reg + CNT_W'(1);
                    end else begin
                        ovf_next = 1'b1;
                    end
                    if (s_tlast) begin
                        state_next = ST_START;
                    end
                end
            end
            ST_START: begin
                idx_next   = '0;
                state_next = ST_SORT;
            end
            ST_SORT: begin
                if (sort_stat.done) begin
                    state_next = ST_EMIT_RD;
                end
            end
            ST_EMIT_RD: begin
                state_next = ST_EMIT_LD;
            end
            ST_EMIT_LD: begin
                out_data_next  = rd_a;
                out_valid_next = 1'b1;
                out_last_next  = (idx_reg == count_reg - CNT_W'(1));
                state_next     = ST_EMIT_WAIT;
            end
            ST_EMIT_WAIT: begin
                if (m_tready) begin
                    out_valid_next = 1'b0;
                    if (out_last_reg) begin
                        // array done, start collecting the next one
                        count_next = '0;
                        ovf_next   = 1'b0;
                        state_next = ST_LOAD;
                    end else begin
                        idx_next   = idx_reg + CNT_W'(1);
                        state_next = ST_EMIT_RD;
                    end
                end
            end
            default: begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_LOAD;
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            out_last_reg  <= 1'b0;
        end else begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            ovf_reg       <= ovf_next;
            out_valid_reg <= out_valid_next;
            out_last_reg  <= out_last_next;
        end
        idx_reg      <= idx_next;
        out_data_reg <= out_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;
    assign m_tuser  = ovf_reg;

endmodule

// ===== tb/sv/tb_merge_sort_engine.sv =====
`timescale 1ns / 1ps

module tb_merge_sort_engine;

    localparam int DEPTH      = mse_pkg::DEPTH_DEFAULT;
    localparam int STALL_MAX  = 20000;
    localparam int RAND_ITEMS = 180;

    typedef struct packed {
        logic [31:0] value;
        logic        last;
        logic        dropped;
    } sorted_t;

    // keeps the array being loaded and the sorted values still owed by the block
    class array_sorter;
        int          capacity;
        logic [31:0] loaded_values[$];
        logic        overflow;
        sorted_t     sorted_pending[$];
        int          mismatches;

        function new(int cap);
            capacity   = cap;
            overflow   = 1'b0;
            mismatches = 0;
        endfunction

        function void sort_loaded();
            int          i;
            int          j;
            logic [31:0] key;
            for (i = 1; i < loaded_values.size(); i++) begin
                key = loaded_values[i];
                j = i - 1;
                while (j >= 0 && $signed(loaded_values[j]) > $signed(key)) begin
                    loaded_values[j + 1] = loaded_values[j];
                    j--;
                end
                loaded_values[j + 1] = key;
            end
        endfunction

        function void note_request(logic [31:0] value, logic last);
            sorted_t res;
            int      k;
            if (loaded_values.size() < capacity)
                loaded_values = {loaded_values, value};
            else
                overflow = 1'b1;
            if (last) begin
                sort_loaded();
                for (k = 0; k < loaded_values.size(); k++) begin
                    res.value   = loaded_values[k];
                    res.last    = (k == loaded_values.size() - 1);
                    res.dropped = overflow;
                    sorted_pending = {sorted_pending, res};
                end
                loaded_values.delete();
                overflow = 1'b0;
            end
        endfunction

        function void check_result(logic [31:0] value, logic last, logic dropped);
            sorted_t want;
            if (sorted_pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: value %0d last %0b dropped %0b",
                             $signed(value), last, dropped);
            end else begin
                want = sorted_pending.pop_front();
                if (want.value !== value || want.last !== last || want.dropped !== dropped) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"mismatch: expected value %0d last %0b dropped %0b, ",
                                  "got value %0d last %0b dropped %0b"},
                                 $signed(want.value), want.last, want.dropped,
                                 $signed(value), last, dropped);
                end
            end
        endfunction
    endclass

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata  = '0;   // [31:0] value
    logic        s_tlast  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;         // [31:0] sorted_value
    logic        m_tlast;
    logic        m_tuser;         // [0] dropped

    array_sorter sorter = new(DEPTH);
    int          idle_cycles = 0;
    int          ready_hold  = 0;
    bit          burst_mode  = 0;

    merge_sort_engine #(.DEPTH(DEPTH)) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    always #6 aclk = ~aclk;

    // request and result monitors, plus a watchdog on lack of progress
    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready)
            sorter.note_request(s_tdata, s_tlast);
        if (aresetn && m_tvalid && m_tready)
            sorter.check_result(m_tdata, m_tlast, m_tuser);
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_MAX) begin
            $display("timeout: no progress for %0d cycles", STALL_MAX);
            $display("FAIL merge_sort_engine");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // result side back-pressure: long ready runs, short stalls, a few long ones
    always @(negedge aclk) begin
        int r;
        if (ready_hold > 0) begin
            ready_hold <= ready_hold - 1;
        end else begin
            r = $urandom_range(0, 9);
            if (r < 6) begin
                m_tready   <= 1'b1;
                ready_hold <= $urandom_range(0, 23);
            end else if (r < 9) begin
                m_tready   <= 1'b0;
                ready_hold <= $urandom_range(0, 2);
            end else begin
                m_tready   <= 1'b0;
                ready_hold <= $urandom_range(14, 49);
            end
        end
    end

    function automatic int pick_gap();
        int r;
        if (burst_mode)
            return 0;
        r = $urandom_range(0, 19);
        if (r < 10)
            return 0;
        if (r < 18)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 9))
            0: begin
                case ($urandom_range(0, 3))
                    0: return 32'h8000_0000;
                    1: return 32'h7fff_ffff;
                    2: return 32'h0000_0000;
                    default: return 32'hffff_ffff;
                endcase
            end
            1, 2, 3: return $urandom_range(0, 15) - 8;
            default: return $urandom;
        endcase
    endfunction

    task automatic send_request(logic [31:0] value, logic last);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic send_array(logic [31:0] values[$]);
        int k;
        for (k = 0; k < values.size(); k++)
            send_request(values[k], k == values.size() - 1);
    endtask

    task automatic wait_drained();
        while (sorter.sorted_pending.size() != 0)
            @(posedge aclk);
    endtask

    initial begin
        logic [31:0] arr[$];
        int          sent;
        int          len;
        int          idx;
        int          k;

        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // single-element arrays at both extremes
        arr = '{32'h7fff_ffff};
        send_array(arr);
        arr = '{32'h8000_0000};
        send_array(arr);
        // extremes with repeats
        arr = '{32'h0, 32'hffff_ffff, 32'h7fff_ffff, 32'h8000_0000, 32'h1,
                32'h8000_0000, 32'h7fff_ffff};
        send_array(arr);
        // all equal
        arr = '{32'd5, 32'd5, 32'd5, 32'd5};
        send_array(arr);
        // reverse order
        arr.delete();
        for (k = 4; k >= -3; k--)
            arr = {arr, 32'(k)};
        send_array(arr);

        // hold off until the block has returned everything
        wait_drained();

        sent = 0;
        idx  = 0;
        while (sent < RAND_ITEMS) begin
            burst_mode = ($urandom_range(0, 4) == 0);
            if (idx == 2)
                len = DEPTH;            // exactly full
            else if (idx == 5)
                len = DEPTH + 3;        // overflow, last three requests dropped
            else if ($urandom_range(0, 6) == 0)
                len = $urandom_range(13, 40);
            else
                len = $urandom_range(1, 12);
            arr.delete();
            for (k = 0; k < len; k++)
                arr = {arr, pick_value()};
            send_array(arr);
            sent += len;
            idx++;
            if (idx == 8)
                wait_drained();
        end
        burst_mode = 0;
        @(negedge aclk);
        s_tvalid <= 1'b0;

        wait_drained();
        repeat (40) @(posedge aclk);
        if (sorter.mismatches == 0 && sorter.sorted_pending.size() == 0) begin
            $display("PASS merge_sort_engine");
        end else begin
            $display("FAIL merge_sort_engine");
        end
        $finish;
    end

endmodule

// ===== merge_sort_engine.f =====
src/mse_pkg.sv
src/mse_ram.sv
src/mse_sorter.sv
src/merge_sort_engine.sv
tb/sv/tb_merge_sort_engine.sv
